### sv/sqt_pkg.sv
// Shared types, constants and fixed-point helpers of the sprite quad transform.
`default_nettype none
package sqt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_ANGLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_ZOOM  = 2'd3;

  localparam int POS_W   = 32;
  localparam int DIM_W   = 31;
  localparam int ANG_W   = 16;
  localparam int SCALE_W = 16;
  localparam int TEX_W   = 17;
  localparam int UV_W    = 18;
  localparam int COLOR_W = 32;
  localparam int ZOOM_W  = 16;

  localparam logic [ANG_W-1:0]  ANG_QUARTER = 16'd16384;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET  = 16'd256;

  // Widths that cover the whole supported range of fraction bits.
  localparam int K_W   = 34;
  localparam int CO_W  = 44;
  localparam int T2_W  = 34;
  localparam int V_W   = 42;
  localparam int VT_W  = 44;
  localparam int PX_W  = 50;
  localparam int MUL_W = 96;

  localparam logic [63:0] PC1 = 64'd1686629713;
  localparam logic [63:0] PC3 = 64'd693598668;
  localparam logic [63:0] PC5 = 64'd85569306;
  localparam logic [63:0] PC7 = 64'd5026994;
  localparam logic [63:0] PC9 = 64'd172273;

  typedef struct packed {
    logic signed [POS_W-1:0]   obj_x;
    logic signed [POS_W-1:0]   obj_y;
    logic [DIM_W-1:0]          obj_width;
    logic [DIM_W-1:0]          obj_height;
    logic [ANG_W-1:0]          obj_angle;
    logic signed [SCALE_W-1:0] obj_scale_x;
    logic signed [SCALE_W-1:0] obj_scale_y;
    logic [TEX_W-1:0]          tex_left;
    logic [TEX_W-1:0]          tex_top;
    logic [TEX_W-1:0]          tex_width;
    logic [TEX_W-1:0]          tex_height;
    logic [COLOR_W-1:0]        tint;
  } sprite_t;

  typedef struct packed {
    logic signed [K_W-1:0]  k0;
    logic signed [K_W-1:0]  k1;
    logic signed [CO_W-1:0] k4;
    logic signed [CO_W-1:0] k5;
  } cam_coef_t;

  typedef struct packed {
    logic signed [V_W-1:0]  v0;
    logic signed [V_W-1:0]  v1;
    logic signed [V_W-1:0]  v2;
    logic signed [V_W-1:0]  v3;
    logic signed [VT_W-1:0] v4;
    logic signed [VT_W-1:0] v5;
    logic [DIM_W-1:0]       w;
    logic [DIM_W-1:0]       h;
    logic [UV_W-1:0]        u_lo;
    logic [UV_W-1:0]        u_hi;
    logic [UV_W-1:0]        v_lo;
    logic [UV_W-1:0]        v_hi;
    logic [COLOR_W-1:0]     tint;
  } quad_t;

  // Arithmetic shift right with rounding half away from zero.
  function automatic logic signed [MUL_W-1:0] rshr(input logic signed [MUL_W-1:0] p,
                                                     input int unsigned sh);
    logic signed [MUL_W-1:0] half;
    half = 96'sd1 <<< (sh - 1);
    return (p + half - $signed({95'd0, p[MUL_W-1]})) >>> sh;
  endfunction

  function automatic logic signed [MUL_W-1:0] mul_rnd(input logic signed [MUL_W-1:0] a,
                                                        input logic signed [MUL_W-1:0] b,
                                                        input int unsigned sh);
    return rshr(a * b, sh);
  endfunction

  // Sine of a 16-bit phase, odd polynomial on the quarter wave, rounded to frac bits.
  function automatic logic signed [31:0] sine_of_phase(input logic [15:0] a,
                                                        input int unsigned frac);
    logic [1:0]  q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s30;
    logic [63:0] sq;
    q = a[15:14];
    r = {50'd0, a[13:0]};
    if (q[0]) begin
      r = 64'd16384 - r;
    end
    x = r << 16;
    x2 = (x * x) >> 30;
    p = PC9;
    p = PC7 - ((x2 * p) >> 30);
    p = PC5 - ((x2 * p) >> 30);
    p = PC3 - ((x2 * p) >> 30);
    p = PC1 - ((x2 * p) >> 30);
    s30 = (x * p) >> 30;
    sq = (s30 + (64'd1 << (29 - frac))) >> (30 - frac);
    if (sq > (64'd1 << frac)) begin
      sq = 64'd1 << frac;
    end
    return q[1] ? -$signed(sq[31:0]) : $signed(sq[31:0]);
  endfunction

endpackage
`default_nettype wire

### sv/sprite_quad_transform.sv
// Top level of the sprite quad transform: sprite in, four transformed vertices out.
// An accepted sprite passes the model pipeline and the emitter's registers before its first vertex reaches the output.
// The sprite rate is set by the emitter, which sends one vertex per cycle while m_tready is high.
// After reset and after every configuration write, the camera sequencer runs with s_tready low;
// it computes the zoom reciprocal one quotient bit per cycle.
// Reset is synchronous and active high; it loads the camera registers' reset values.
`default_nettype none
module sprite_quad_transform #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // obj_x, obj_y, obj_width, obj_height, obj_angle, obj_scale_x, obj_scale_y,
  // tex_left, tex_top, tex_width, tex_height, tint, zero fill
  input  logic [279:0]                    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // vert_x, vert_y, vert_u, vert_v, vert_color, zero fill
  output logic [135:0]                    m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [sqt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sqt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sqt_pkg::*;

  sprite_t   sprite;
  cam_coef_t coef;
  quad_t     quad;
  logic      busy;
  logic      model_ready;
  logic      quad_valid;
  logic      quad_ready;

  logic signed [POS_W-1:0] vert_x;
  logic signed [POS_W-1:0] vert_y;
  logic [UV_W-1:0]         vert_u;
  logic [UV_W-1:0]         vert_v;
  logic [COLOR_W-1:0]      vert_color;

  assign sprite.obj_x       = $signed(s_tdata[31:0]);
  assign sprite.obj_y       = $signed(s_tdata[63:32]);
  assign sprite.obj_width   = s_tdata[94:64];
  assign sprite.obj_height  = s_tdata[125:95];
  assign sprite.obj_angle   = s_tdata[141:126];
  assign sprite.obj_scale_x = $signed(s_tdata[157:142]);
  assign sprite.obj_scale_y = $signed(s_tdata[173:158]);
  assign sprite.tex_left    = s_tdata[190:174];
  assign sprite.tex_top     = s_tdata[207:191];
  assign sprite.tex_width   = s_tdata[224:208];
  assign sprite.tex_height  = s_tdata[241:225];
  assign sprite.tint        = s_tdata[273:242];

  assign s_tready = model_ready && !busy;
  assign m_tdata  = {4'd0, vert_color, vert_v, vert_u, vert_y, vert_x};

  sqt_camera #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_camera (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .busy(busy),
    .coef(coef)
  );

  sqt_model #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_model (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid && !busy),
    .in_ready(model_ready),
    .in_data(sprite),
    .coef(coef),
    .out_valid(quad_valid),
    .out_ready(quad_ready),
    .out_data(quad)
  );

  sqt_emit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_emit (
    .clk(clk),
    .rst(rst),
    .in_valid(quad_valid),
    .in_ready(quad_ready),
    .in_data(quad),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .vert_x(vert_x),
    .vert_y(vert_y),
    .vert_u(vert_u),
    .vert_v(vert_v),
    .vert_color(vert_color),
    .last_vertex(m_tlast)
  );

endmodule
`default_nettype wire

### sv/sqt_sine_rom.sv
// Constant sine table with two combinational read ports, cosine taken by the caller.
`default_nettype none
module sqt_sine_rom #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic [sqt_pkg::ANG_W-1:0]      ang_a,
  input  logic [sqt_pkg::ANG_W-1:0]      ang_b,
  output logic signed [FRAC_BITS+1:0]    sin_a,
  output logic signed [FRAC_BITS+1:0]    sin_b
);
  import sqt_pkg::*;

  localparam int SW    = FRAC_BITS + 2;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

  logic signed [SW-1:0] sine_rom [SINE_TABLE_DEPTH];
  logic [31:0]          prod_a;
  logic [31:0]          prod_b;
  logic [IDX_W-1:0]     idx_a;
  logic [IDX_W-1:0]     idx_b;

  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    localparam longint PH = (longint'(gi) * 65536) / SINE_TABLE_DEPTH;
    localparam logic [15:0] PHASE = 16'(PH);
    assign sine_rom[gi] = SW'(sine_of_phase(PHASE, FRAC_BITS));
  end

  assign prod_a = 32'(ang_a) * 32'(SINE_TABLE_DEPTH);
  assign prod_b = 32'(ang_b) * 32'(SINE_TABLE_DEPTH);
  assign idx_a  = IDX_W'(prod_a >> 16);
  assign idx_b  = IDX_W'(prod_b >> 16);
  assign sin_a  = sine_rom[idx_a];
  assign sin_b  = sine_rom[idx_b];

endmodule
`default_nettype wire

### sv/sqt_camera.sv
// Camera registers and the sequencer that derives the camera matrix coefficients.
`default_nettype none
module sqt_camera #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sqt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sqt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              busy,
  output sqt_pkg::cam_coef_t                coef
);
  import sqt_pkg::*;

  localparam int SW = FRAC_BITS + 2;
  localparam int NW = FRAC_BITS + 9;
  localparam int CW = $clog2(NW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_K01  = 3'd3;
  localparam logic [2:0] ST_PROD = 3'd4;
  localparam logic [2:0] ST_SUM  = 3'd5;

  logic signed [POS_W-1:0] camera_x;
  logic signed [POS_W-1:0] camera_y;
  logic [ANG_W-1:0]        camera_angle;
  logic [ZOOM_W-1:0]       camera_zoom;
  logic [2:0]              state;
  logic [NW-1:0]           quot;
  logic [ZOOM_W:0]         rem;
  logic [ZOOM_W-1:0]       dvs;
  logic [CW-1:0]           cnt;
  logic signed [K_W-1:0]   k0;
  logic signed [K_W-1:0]   k1;
  logic signed [CO_W-1:0]  p0;
  logic signed [CO_W-1:0]  p1;
  logic signed [CO_W-1:0]  p2;
  logic signed [CO_W-1:0]  p3;

  logic [ANG_W-1:0]        neg_angle;
  logic signed [SW-1:0]    cos_q;
  logic signed [SW-1:0]    sin_q;
  logic [ZOOM_W-1:0]       zoom_div;
  logic [ZOOM_W:0]         rem_sh;
  logic                    fits;

  assign neg_angle = -camera_angle;
  assign zoom_div  = (camera_zoom == '0) ? ZOOM_W'(1) : camera_zoom;
  assign rem_sh    = {rem[ZOOM_W-1:0], quot[NW-1]};
  assign fits      = rem_sh >= {1'b0, dvs};
  assign busy      = state != ST_IDLE;

  sqt_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_rom (
    .ang_a(neg_angle + ANG_QUARTER),
    .ang_b(neg_angle),
    .sin_a(cos_q),
    .sin_b(sin_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x     <= '0;
      camera_y     <= '0;
      camera_angle <= '0;
      camera_zoom  <= ZOOM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAMERA_X:     camera_x     <= $signed(cfg_data[POS_W-1:0]);
        REG_CAMERA_Y:     camera_y     <= $signed(cfg_data[POS_W-1:0]);
        REG_CAMERA_ANGLE: camera_angle <= cfg_data[ANG_W-1:0];
        REG_CAMERA_ZOOM:  camera_zoom  <= cfg_data[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else if (cfg_we) begin
      state <= ST_LOAD;
    end else begin
      case (state)
        ST_LOAD: state <= ST_DIV;
        ST_DIV: begin
          if (cnt == CW'(NW - 1)) begin
            state <= ST_K01;
          end
        end
        ST_K01:  state <= ST_PROD;
        ST_PROD: state <= ST_SUM;
        ST_SUM:  state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        quot <= (NW'(1) << (FRAC_BITS + 8)) + NW'(zoom_div >> 1);
        rem  <= '0;
        dvs  <= zoom_div;
        cnt  <= '0;
      end
      ST_DIV: begin
        rem  <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
        quot <= {quot[NW-2:0], fits};
        cnt  <= cnt + CW'(1);
      end
      ST_K01: begin
        k0 <= K_W'(mul_rnd(MUL_W'(cos_q), MUL_W'($signed({1'b0, quot})), FRAC_BITS));
        k1 <= K_W'(mul_rnd(MUL_W'(sin_q), MUL_W'($signed({1'b0, quot})), FRAC_BITS));
      end
      ST_PROD: begin
        p0 <= CO_W'(mul_rnd(MUL_W'(camera_x), MUL_W'(k0), FRAC_BITS));
        p1 <= CO_W'(mul_rnd(MUL_W'(camera_y), -MUL_W'(k1), FRAC_BITS));
        p2 <= CO_W'(mul_rnd(MUL_W'(camera_x), MUL_W'(k1), FRAC_BITS));
        p3 <= CO_W'(mul_rnd(MUL_W'(camera_y), MUL_W'(k0), FRAC_BITS));
      end
      ST_SUM: begin
        coef.k0 <= k0;
        coef.k1 <= k1;
        coef.k4 <= -(p0 + p1);
        coef.k5 <= -(p2 + p3);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/sqt_model.sv
// Five-stage pipeline that composes the camera and sprite matrices for each sprite.
`default_nettype none
module sqt_model #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sqt_pkg::sprite_t    in_data,
  input  sqt_pkg::cam_coef_t  coef,
  output logic                out_valid,
  input  logic                out_ready,
  output sqt_pkg::quad_t      out_data
);
  import sqt_pkg::*;

  localparam int SW = FRAC_BITS + 2;
  localparam int MW = FRAC_BITS + 10;

  typedef struct packed {
    logic signed [SW-1:0]      mc;
    logic signed [SW-1:0]      ms;
    logic signed [T2_W-1:0]    tx2;
    logic signed [T2_W-1:0]    ty2;
    logic signed [SCALE_W-1:0] scx;
    logic signed [SCALE_W-1:0] scy;
  } rot_t;

  typedef struct packed {
    logic signed [MW-1:0]   m0;
    logic signed [MW-1:0]   m1;
    logic signed [MW-1:0]   m2;
    logic signed [MW-1:0]   m3;
    logic signed [T2_W-1:0] tx2;
    logic signed [T2_W-1:0] ty2;
  } mat_t;

  typedef struct packed {
    logic signed [V_W-1:0]  a0;
    logic signed [V_W-1:0]  a1;
    logic signed [V_W-1:0]  b0;
    logic signed [V_W-1:0]  b1;
    logic signed [V_W-1:0]  c0;
    logic signed [V_W-1:0]  c1;
    logic signed [V_W-1:0]  d0;
    logic signed [V_W-1:0]  d1;
    logic signed [VT_W-1:0] e0;
    logic signed [VT_W-1:0] e1;
    logic signed [VT_W-1:0] f0;
    logic signed [VT_W-1:0] f1;
  } prod_t;

  logic    v1, v2, v3, v4, v5;
  logic    en1, en2, en3, en4, en5;
  sprite_t s1;
  rot_t    r2;
  mat_t    m3;
  prod_t   p4;
  quad_t   q2, q3, q4;

  logic signed [SW-1:0] cos_q;
  logic signed [SW-1:0] sin_q;
  logic signed [K_W-1:0] k2;

  assign en5       = !v5 || out_ready;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v5;
  assign k2        = -coef.k1;

  sqt_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_rom (
    .ang_a(s1.obj_angle + ANG_QUARTER),
    .ang_b(s1.obj_angle),
    .sin_a(cos_q),
    .sin_b(sin_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1 <= in_data;
    end
    if (en2) begin
      r2.mc   <= cos_q;
      r2.ms   <= sin_q;
      r2.tx2  <= $signed({s1.obj_x[POS_W-1], s1.obj_x, 1'b0}) +
                 $signed({3'b000, s1.obj_width});
      r2.ty2  <= $signed({s1.obj_y[POS_W-1], s1.obj_y, 1'b0}) +
                 $signed({3'b000, s1.obj_height});
      r2.scx  <= s1.obj_scale_x;
      r2.scy  <= s1.obj_scale_y;
      q2.v0   <= '0;
      q2.v1   <= '0;
      q2.v2   <= '0;
      q2.v3   <= '0;
      q2.v4   <= '0;
      q2.v5   <= '0;
      q2.w    <= s1.obj_width;
      q2.h    <= s1.obj_height;
      q2.u_lo <= UV_W'(s1.tex_left);
      q2.u_hi <= UV_W'(s1.tex_left) + UV_W'(s1.tex_width);
      q2.v_lo <= UV_W'(s1.tex_top);
      q2.v_hi <= UV_W'(s1.tex_top) + UV_W'(s1.tex_height);
      q2.tint <= s1.tint;
    end
    if (en3) begin
      m3.m0  <= MW'(mul_rnd(MUL_W'(r2.mc), MUL_W'(r2.scx), 8));
      m3.m1  <= MW'(mul_rnd(MUL_W'(r2.ms), MUL_W'(r2.scx), 8));
      m3.m2  <= MW'(-mul_rnd(MUL_W'(r2.ms), MUL_W'(r2.scy), 8));
      m3.m3  <= MW'(mul_rnd(MUL_W'(r2.mc), MUL_W'(r2.scy), 8));
      m3.tx2 <= r2.tx2;
      m3.ty2 <= r2.ty2;
      q3     <= q2;
    end
    if (en4) begin
      p4.a0 <= V_W'(mul_rnd(MUL_W'(coef.k0), MUL_W'(m3.m0), FRAC_BITS));
      p4.a1 <= V_W'(mul_rnd(MUL_W'(k2), MUL_W'(m3.m1), FRAC_BITS));
      p4.b0 <= V_W'(mul_rnd(MUL_W'(coef.k1), MUL_W'(m3.m0), FRAC_BITS));
      p4.b1 <= V_W'(mul_rnd(MUL_W'(coef.k0), MUL_W'(m3.m1), FRAC_BITS));
      p4.c0 <= V_W'(mul_rnd(MUL_W'(coef.k0), MUL_W'(m3.m2), FRAC_BITS));
      p4.c1 <= V_W'(mul_rnd(MUL_W'(k2), MUL_W'(m3.m3), FRAC_BITS));
      p4.d0 <= V_W'(mul_rnd(MUL_W'(coef.k1), MUL_W'(m3.m2), FRAC_BITS));
      p4.d1 <= V_W'(mul_rnd(MUL_W'(coef.k0), MUL_W'(m3.m3), FRAC_BITS));
      p4.e0 <= VT_W'(mul_rnd(MUL_W'(coef.k0), MUL_W'(m3.tx2), FRAC_BITS + 1));
      p4.e1 <= VT_W'(mul_rnd(MUL_W'(k2), MUL_W'(m3.ty2), FRAC_BITS + 1));
      p4.f0 <= VT_W'(mul_rnd(MUL_W'(coef.k1), MUL_W'(m3.tx2), FRAC_BITS + 1));
      p4.f1 <= VT_W'(mul_rnd(MUL_W'(coef.k0), MUL_W'(m3.ty2), FRAC_BITS + 1));
      q4    <= q3;
    end
    if (en5) begin
      out_data.w    <= q4.w;
      out_data.h    <= q4.h;
      out_data.u_lo <= q4.u_lo;
      out_data.u_hi <= q4.u_hi;
      out_data.v_lo <= q4.v_lo;
      out_data.v_hi <= q4.v_hi;
      out_data.tint <= q4.tint;
      out_data.v0   <= p4.a0 + p4.a1;
      out_data.v1   <= p4.b0 + p4.b1;
      out_data.v2   <= p4.c0 + p4.c1;
      out_data.v3   <= p4.d0 + p4.d1;
      out_data.v4   <= p4.e0 + p4.e1 + VT_W'(coef.k4);
      out_data.v5   <= p4.f0 + p4.f1 + VT_W'(coef.k5);
    end
  end

endmodule
`default_nettype wire

### sv/sqt_emit.sv
// Vertex emitter: walks the four corners of a quad and saturates screen positions.
`default_nettype none
module sqt_emit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  sqt_pkg::quad_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sqt_pkg::POS_W-1:0]  vert_x,
  output logic signed [sqt_pkg::POS_W-1:0]  vert_y,
  output logic [sqt_pkg::UV_W-1:0]          vert_u,
  output logic [sqt_pkg::UV_W-1:0]          vert_v,
  output logic [sqt_pkg::COLOR_W-1:0]       vert_color,
  output logic                              last_vertex
);
  import sqt_pkg::*;

  localparam int SUM_W = PX_W + 2;
  localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd2147483648);

  quad_t      hq;
  logic       hv;
  logic [1:0] cnt;
  logic       e1v;
  logic       en_e1;
  logic       en_o;

  logic signed [PX_W-1:0]  pa, pb, pc, pd;
  logic signed [VT_W-1:0]  e1_v4, e1_v5;
  logic [UV_W-1:0]         e1_u, e1_v;
  logic [COLOR_W-1:0]      e1_color;
  logic                    e1_last;

  logic signed [DIM_W+1:0] lx, ly;
  logic signed [SUM_W-1:0] sx, sy;

  assign en_o     = !out_valid || out_ready;
  assign en_e1    = !e1v || en_o;
  assign in_ready = !hv || (cnt == 2'd3 && en_e1);

  assign lx = cnt[0] ? $signed({2'b00, hq.w}) : -$signed({2'b00, hq.w});
  assign ly = cnt[1] ? $signed({2'b00, hq.h}) : -$signed({2'b00, hq.h});
  assign sx = SUM_W'(pa) + SUM_W'(pb) + SUM_W'(e1_v4);
  assign sy = SUM_W'(pc) + SUM_W'(pd) + SUM_W'(e1_v5);

  always_ff @(posedge clk) begin
    if (rst) begin
      hv        <= 1'b0;
      cnt       <= 2'd0;
      e1v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        hv  <= in_valid;
        cnt <= 2'd0;
      end else if (en_e1) begin
        cnt <= cnt + 2'd1;
      end
      if (en_e1) e1v <= hv;
      if (en_o) out_valid <= e1v;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      hq <= in_data;
    end
    if (en_e1) begin
      pa       <= PX_W'(mul_rnd(MUL_W'(hq.v0), MUL_W'(lx), FRAC_BITS + 1));
      pb       <= PX_W'(mul_rnd(MUL_W'(hq.v2), MUL_W'(ly), FRAC_BITS + 1));
      pc       <= PX_W'(mul_rnd(MUL_W'(hq.v1), MUL_W'(lx), FRAC_BITS + 1));
      pd       <= PX_W'(mul_rnd(MUL_W'(hq.v3), MUL_W'(ly), FRAC_BITS + 1));
      e1_v4    <= hq.v4;
      e1_v5    <= hq.v5;
      e1_u     <= cnt[0] ? hq.u_hi : hq.u_lo;
      e1_v     <= cnt[1] ? hq.v_lo : hq.v_hi;
      e1_color <= hq.tint;
      e1_last  <= cnt == 2'd3;
    end
    if (en_o) begin
      if (sx > POS_MAX) begin
        vert_x <= POS_W'(POS_MAX);
      end else if (sx < POS_MIN) begin
        vert_x <= POS_W'(POS_MIN);
      end else begin
        vert_x <= POS_W'(sx);
      end
      if (sy > POS_MAX) begin
        vert_y <= POS_W'(POS_MAX);
      end else if (sy < POS_MIN) begin
        vert_y <= POS_W'(POS_MIN);
      end else begin
        vert_y <= POS_W'(sy);
      end
      vert_u      <= e1_u;
      vert_v      <= e1_v;
      vert_color  <= e1_color;
      last_vertex <= e1_last;
    end
  end

endmodule
`default_nettype wire

### tb/sprite_quad_transform_test.sv
// Self-checking testbench for the sprite quad transform, with directed and random sprites.
`default_nettype none
module sprite_quad_transform_test;
  import sqt_pkg::*;

  localparam int FB = 16;
  localparam int DEPTH = 1024;
  localparam int RANDOM_SPRITES = 240;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [17:0]        u;
    logic [17:0]        v;
    logic [31:0]        color;
    logic               last;
  } vertex_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [279:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [135:0] m_tdata;
  logic m_tlast;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic signed [63:0] cam_x;
  logic signed [63:0] cam_y;
  logic [15:0] cam_angle;
  logic [15:0] cam_zoom;

  vertex_t expected_vertices[$];
  int errors;
  int idle_cycles;
  int sink_gap;
  bit sink_free;
  bit sink_hold;
  bit sender_done;

  sprite_quad_transform u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_neg(input logic signed [63:0] a);
    if (a == 64'sh8000_0000_0000_0000) return 64'sh7FFF_FFFF_FFFF_FFFF;
    return -a;
  endfunction

  // Exact product, rounded half away from zero, saturated to 64 bits.
  function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                        input logic signed [63:0] b,
                                                        input int sh);
    logic signed [129:0] p;
    logic [129:0] mag;
    logic signed [129:0] r;
    p = 130'(a) * 130'(b);
    mag = p < 0 ? -p : p;
    mag = (mag + (130'd1 << (sh - 1))) >> sh;
    r = p < 0 ? -$signed(mag) : $signed(mag);
    if (r > 130'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (r < -130'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return r[63:0];
  endfunction

  function automatic logic signed [63:0] table_sine(input logic [15:0] angle);
    logic [63:0] idx;
    logic [15:0] ph;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] poly;
    logic [63:0] s30;
    logic signed [63:0] sq;
    idx = (64'(angle) * DEPTH) >> 16;
    ph = 16'((idx << 16) / DEPTH);
    r = 64'(ph[13:0]);
    if (ph[14]) r = 64'd16384 - r;
    x = r << 16;
    x2 = (x * x) >> 30;
    poly = 64'd172273;
    poly = 64'd5026994 - ((x2 * poly) >> 30);
    poly = 64'd85569306 - ((x2 * poly) >> 30);
    poly = 64'd693598668 - ((x2 * poly) >> 30);
    poly = 64'd1686629713 - ((x2 * poly) >> 30);
    s30 = (x * poly) >> 30;
    sq = $signed((s30 + (64'd1 << (29 - FB))) >> (30 - FB));
    if (sq > (64'sd1 <<< FB)) sq = 64'sd1 <<< FB;
    return ph[15] ? -sq : sq;
  endfunction

  task automatic predict_quad(input sprite_t s);
    logic [15:0] zm;
    logic signed [63:0] z, na, cc, cs, k0, k1, k2, k3, k4, k5, mc, ms;
    logic signed [63:0] m0, m1, m2, m3, tx2, ty2, a0, a1, a2, a3, a4, a5;
    logic signed [63:0] w, h, lx, ly, px, py;
    vertex_t vx;
    zm = cam_zoom == 0 ? 16'd1 : cam_zoom;
    z = ((64'd1 << (FB + 8)) + zm / 2) / zm;
    na = 64'((16'd0 - cam_angle));
    cc = table_sine(16'(na + 16384));
    cs = table_sine(16'(na));
    k0 = scaled_product(cc, z, FB);
    k1 = scaled_product(cs, z, FB);
    k2 = sat_neg(k1);
    k3 = k0;
    k4 = sat_neg(sat_add(scaled_product(cam_x, k0, FB), scaled_product(cam_y, k2, FB)));
    k5 = sat_neg(sat_add(scaled_product(cam_x, k1, FB), scaled_product(cam_y, k3, FB)));
    mc = table_sine(s.obj_angle + ANG_QUARTER);
    ms = table_sine(s.obj_angle);
    m0 = scaled_product(mc, 64'(s.obj_scale_x), 8);
    m1 = scaled_product(ms, 64'(s.obj_scale_x), 8);
    m2 = sat_neg(scaled_product(ms, 64'(s.obj_scale_y), 8));
    m3 = scaled_product(mc, 64'(s.obj_scale_y), 8);
    w = 64'(s.obj_width);
    h = 64'(s.obj_height);
    tx2 = 2 * 64'(s.obj_x) + w;
    ty2 = 2 * 64'(s.obj_y) + h;
    a0 = sat_add(scaled_product(k0, m0, FB), scaled_product(k2, m1, FB));
    a1 = sat_add(scaled_product(k1, m0, FB), scaled_product(k3, m1, FB));
    a2 = sat_add(scaled_product(k0, m2, FB), scaled_product(k2, m3, FB));
    a3 = sat_add(scaled_product(k1, m2, FB), scaled_product(k3, m3, FB));
    a4 = sat_add(sat_add(scaled_product(k0, tx2, FB + 1), scaled_product(k2, ty2, FB + 1)), k4);
    a5 = sat_add(sat_add(scaled_product(k1, tx2, FB + 1), scaled_product(k3, ty2, FB + 1)), k5);
    for (int i = 0; i < 4; i++) begin
      lx = i[0] ? w : -w;
      ly = i[1] ? h : -h;
      px = sat_add(sat_add(scaled_product(a0, lx, FB + 1), scaled_product(a2, ly, FB + 1)), a4);
      py = sat_add(sat_add(scaled_product(a1, lx, FB + 1), scaled_product(a3, ly, FB + 1)), a5);
      if (px > 64'sd2147483647) px = 64'sd2147483647;
      if (px < -64'sd2147483648) px = -64'sd2147483648;
      if (py > 64'sd2147483647) py = 64'sd2147483647;
      if (py < -64'sd2147483648) py = -64'sd2147483648;
      vx.x = px[31:0];
      vx.y = py[31:0];
      vx.u = i[0] ? 18'(s.tex_left) + 18'(s.tex_width) : 18'(s.tex_left);
      vx.v = i[1] ? 18'(s.tex_top) : 18'(s.tex_top) + 18'(s.tex_height);
      vx.color = s.tint;
      vx.last = (i == 3);
      expected_vertices.push_back(vx);
    end
  endtask

  function automatic logic [279:0] pack_sprite(input sprite_t s);
    return {6'd0, s.tint, s.tex_height, s.tex_width, s.tex_top, s.tex_left,
            s.obj_scale_y, s.obj_scale_x, s.obj_angle, s.obj_height, s.obj_width,
            s.obj_y, s.obj_x};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAMERA_X: cam_x = 64'($signed(val));
      REG_CAMERA_Y: cam_y = 64'($signed(val));
      REG_CAMERA_ANGLE: cam_angle = val[15:0];
      REG_CAMERA_ZOOM: cam_zoom = val[15:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_sprite(input sprite_t s, input bit gaps);
    if (gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_sprite(s);
    predict_quad(s);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic sprite_t random_sprite();
    sprite_t s;
    s.obj_x = $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    s.obj_y = $urandom_range(0, 3) == 0 ? $urandom() : 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
    s.obj_width = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 1 << 24));
    s.obj_height = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 1 << 24));
    s.obj_angle = 16'($urandom());
    s.obj_scale_x = 16'($urandom());
    s.obj_scale_y = 16'($urandom());
    s.tex_left = 17'($urandom_range(0, 65536));
    s.tex_top = 17'($urandom_range(0, 65536));
    s.tex_width = 17'($urandom_range(0, 65536));
    s.tex_height = 17'($urandom_range(0, 65536));
    if ($urandom_range(0, 7) == 0) begin
      s.tex_left = 17'($urandom_range(65536, 131071));
      s.tex_height = 17'($urandom_range(65536, 131071));
    end
    s.tint = $urandom();
    return s;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else if (sink_hold) begin
      m_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      m_tready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (!sink_free && m_tready && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      sink_gap <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    vertex_t want;
    vertex_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.x = m_tdata[31:0];
      got.y = m_tdata[63:32];
      got.u = m_tdata[81:64];
      got.v = m_tdata[99:82];
      got.color = m_tdata[131:100];
      got.last = m_tlast;
      if (expected_vertices.size() == 0) begin
        report_mismatch("unexpected vertex", 64'(got.x), 64'd0);
      end else begin
        want = expected_vertices.pop_front();
        if (got.x != want.x) report_mismatch("vert_x", 64'(got.x), 64'(want.x));
        if (got.y != want.y) report_mismatch("vert_y", 64'(got.y), 64'(want.y));
        if (got.u != want.u) report_mismatch("vert_u", 64'(got.u), 64'(want.u));
        if (got.v != want.v) report_mismatch("vert_v", 64'(got.v), 64'(want.v));
        if (got.color != want.color) report_mismatch("vert_color", 64'(got.color), 64'(want.color));
        if (got.last != want.last) report_mismatch("last_vertex", 64'(got.last), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sprite_quad_transform_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    sink_hold = 1'b0;
    repeat (60) @(posedge clk);
    wait (sender_done == 1'b0 && expected_vertices.size() > 20);
    sink_hold = 1'b1;
    repeat (80) @(posedge clk);
    sink_hold = 1'b0;
  end

  initial begin
    sprite_t directed[$];
    sprite_t s;
    logic [31:0] cam_settings[4][4];
    errors = 0;
    sender_done = 1'b0;
    sink_free = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_CAMERA_X;
    cfg_data = '0;
    cam_x = 0;
    cam_y = 0;
    cam_angle = 16'd0;
    cam_zoom = ZOOM_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Identity camera: a unit sprite at the origin lands exactly on its corners.
    s = '0;
    s.obj_width = 31'h10000;
    s.obj_height = 31'h10000;
    s.obj_scale_x = 16'sh0100;
    s.obj_scale_y = 16'sh0100;
    s.tex_width = 17'h10000;
    s.tex_height = 17'h10000;
    s.tint = 32'hDEADBEEF;
    directed.push_back(s);
    s.obj_x = 32'h7FFFFFFF; s.obj_y = 32'h7FFFFFFF;
    s.obj_width = 31'h7FFFFFFF; s.obj_height = 31'h7FFFFFFF;
    s.obj_scale_x = 16'sh7FFF; s.obj_scale_y = 16'sh7FFF;
    s.tex_left = 17'h1FFFF; s.tex_top = 17'h1FFFF;
    s.tex_width = 17'h1FFFF; s.tex_height = 17'h1FFFF;
    s.tint = 32'hFFFFFFFF; s.obj_angle = 16'hFFFF;
    directed.push_back(s);
    s.obj_x = 32'h80000000; s.obj_y = 32'h80000000;
    s.obj_scale_x = 16'sh8000; s.obj_scale_y = 16'sh8000;
    s.obj_angle = 16'h8000;
    directed.push_back(s);
    for (int a = 0; a < 8; a++) begin
      s = random_sprite();
      s.obj_angle = 16'(a * 8192);
      directed.push_back(s);
    end
    s = '0;
    directed.push_back(s);

    foreach (directed[i]) begin
      send_sprite(directed[i], 1'b0);
      if (i == 0) begin
        s_tvalid <= 1'b0;
        wait_drained();
      end
    end
    s_tvalid <= 1'b0;
    wait_drained();

    cam_settings[0] = '{32'h00010000, 32'hFFFF0000, 32'd4096, 32'd512};
    cam_settings[1] = '{32'h7FFFFFFF, 32'h80000000, 32'hFFFF, 32'd1};
    cam_settings[2] = '{32'h80000000, 32'h7FFFFFFF, 32'h8000, 32'hFFFF};
    cam_settings[3] = '{32'd0, 32'd0, 32'd0, 32'd0};
    for (int phase = 0; phase < 5; phase++) begin
      if (phase < 4) begin
        write_register(REG_CAMERA_X, cam_settings[phase][0]);
        write_register(REG_CAMERA_Y, cam_settings[phase][1]);
        write_register(REG_CAMERA_ANGLE, cam_settings[phase][2]);
        write_register(REG_CAMERA_ZOOM, cam_settings[phase][3]);
      end else begin
        write_register(REG_CAMERA_X, $urandom_range(0, 1 << 22));
        write_register(REG_CAMERA_Y, $urandom());
        write_register(REG_CAMERA_ANGLE, $urandom());
        write_register(REG_CAMERA_ZOOM, $urandom_range(64, 1024));
        sink_free = 1'b1;
      end
      for (int n = 0; n < RANDOM_SPRITES / 5; n++) begin
        send_sprite(random_sprite(), phase < 4);
      end
      s_tvalid <= 1'b0;
      wait_drained();
    end
    sender_done = 1'b1;
    if (errors == 0) begin
      $display("sprite_quad_transform_test: done, clean");
    end else begin
      $display("sprite_quad_transform_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sprite_quad_transform.f
sv/sqt_pkg.sv
sv/sqt_sine_rom.sv
sv/sqt_camera.sv
sv/sqt_model.sv
sv/sqt_emit.sv
sv/sprite_quad_transform.sv
tb/sprite_quad_transform_test.sv
